// File: design/udtc_pkg.sv
// Shared types, constants and functions for the UDF descriptor tag CRC block.
`default_nettype none

package udtc_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 16;
  localparam int unsigned ID_W       = 16;
  localparam int unsigned LOC_W      = 32;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned CNT16_W    = 16;
  localparam int unsigned MAX_BODY_D = 2032;

  localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
  localparam logic [BYTE_W-1:0] TAG_VERSION = 8'd2;

  typedef struct packed {
    logic [CRC_W-1:0]   crc;
    logic [CNT16_W-1:0] count;
    logic               too_long;
    logic [ID_W-1:0]    tag_id;
    logic [LOC_W-1:0]   tag_location;
  } accum_res_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc ^ {data, 8'h00};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [BYTE_W-1:0] tag_sum(input logic [ID_W-1:0] id,
                                                input logic [CRC_W-1:0] crc,
                                                input logic [CNT16_W-1:0] count,
                                                input logic [LOC_W-1:0] loc);
    logic [BYTE_W-1:0] s;
    s = id[7:0] + id[15:8] + TAG_VERSION
      + crc[7:0] + crc[15:8]
      + count[7:0] + count[15:8]
      + loc[7:0] + loc[15:8] + loc[23:16] + loc[31:24];
    return s;
  endfunction

endpackage

`default_nettype wire

// File: design/udtc_accum.sv
// Running CRC, byte count and overflow state for the descriptor body.
`default_nettype none

module udtc_accum #(
  parameter int unsigned MAX_BODY = udtc_pkg::MAX_BODY_D
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire logic [udtc_pkg::BYTE_W-1:0] body_byte,
  input  wire logic                        last_byte,
  input  wire logic [udtc_pkg::ID_W-1:0]   tag_id,
  input  wire logic [udtc_pkg::LOC_W-1:0]  tag_location,
  output udtc_pkg::accum_res_t             res
);
  import udtc_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_BODY + 1);

  logic [CRC_W-1:0] running_crc;
  logic [CRC_W-1:0] running_crc_next;
  logic [CNT_W-1:0] byte_count;
  logic [CNT_W-1:0] byte_count_next;
  logic             overflow_seen;
  logic             overflow_seen_next;

  always_comb begin
    if (byte_count < CNT_W'(MAX_BODY)) begin
      running_crc_next   = crc_byte(running_crc, body_byte);
      byte_count_next    = byte_count + CNT_W'(1);
      overflow_seen_next = overflow_seen;
    end else begin
      running_crc_next   = running_crc;
      byte_count_next    = byte_count;
      overflow_seen_next = 1'b1;
    end
  end

  always_comb begin
    res.crc          = running_crc_next;
    res.count        = CNT16_W'(byte_count_next);
    res.too_long     = overflow_seen_next;
    res.tag_id       = tag_id;
    res.tag_location = tag_location;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc   <= '0;
      byte_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (load) begin
      if (last_byte) begin
        running_crc   <= '0;
        byte_count    <= '0;
        overflow_seen <= 1'b0;
      end else begin
        running_crc   <= running_crc_next;
        byte_count    <= byte_count_next;
        overflow_seen <= overflow_seen_next;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/udtc_result.sv
// Tag checksum and the output register of the result channel.
`default_nettype none

module udtc_result (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         load_last,
  input  wire udtc_pkg::accum_res_t         res,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [udtc_pkg::CRC_W-1:0]        crc_value,
  output logic [udtc_pkg::LEN_W-1:0]        crc_length,
  output logic [udtc_pkg::BYTE_W-1:0]       tag_checksum,
  output logic                              too_long
);
  import udtc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      out_valid <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (load_last) begin
      crc_value    <= res.crc;
      crc_length   <= res.count[LEN_W-1:0];
      tag_checksum <= tag_sum(res.tag_id, res.crc, res.count, res.tag_location);
      too_long     <= res.too_long;
    end
  end

endmodule

`default_nettype wire

// File: design/udf_descriptor_tag_crc_top.sv
// Top level of the UDF descriptor tag CRC and checksum block.
//
//   Channel | Handshake          | Fields
//   --------+--------------------+-------------------------------------------------
//   in      | in_valid/in_stall  | body_byte, last_byte, tag_id, tag_location
//   out     | out_valid/out_stall| crc_value, crc_length, tag_checksum, too_long
//
// One request is taken per cycle while in_stall is low.
// The CRC update and the checksum adder sit between the input and output registers.
// Synchronous reset clears the running CRC, the count and both valid flags.
// While the output register holds an untaken result, the input register holds too,
// and in_stall rises once it is full.
`default_nettype none

module udf_descriptor_tag_crc_top #(
  parameter int unsigned MAX_BODY = udtc_pkg::MAX_BODY_D
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [udtc_pkg::BYTE_W-1:0]  body_byte,
  input  wire logic                         last_byte,
  input  wire logic [udtc_pkg::ID_W-1:0]    tag_id,
  input  wire logic [udtc_pkg::LOC_W-1:0]   tag_location,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [udtc_pkg::CRC_W-1:0]        crc_value,
  output logic [udtc_pkg::LEN_W-1:0]        crc_length,
  output logic [udtc_pkg::BYTE_W-1:0]       tag_checksum,
  output logic                              too_long
);
  import udtc_pkg::*;

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_last;
  logic [ID_W-1:0]   s1_id;
  logic [LOC_W-1:0]  s1_loc;
  logic              out_free;
  logic              load;
  accum_res_t        res;

  assign out_free = !out_valid || !out_stall;
  assign load     = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_byte <= body_byte;
      s1_last <= last_byte;
      s1_id   <= tag_id;
      s1_loc  <= tag_location;
    end
  end

  udtc_accum #(
    .MAX_BODY(MAX_BODY)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .body_byte   (s1_byte),
    .last_byte   (s1_last),
    .tag_id      (s1_id),
    .tag_location(s1_loc),
    .res         (res)
  );

  udtc_result u_result (
    .clk         (clk),
    .rst         (rst),
    .load_last   (load && s1_last),
    .res         (res),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .crc_value   (crc_value),
    .crc_length  (crc_length),
    .tag_checksum(tag_checksum),
    .too_long    (too_long)
  );

endmodule

`default_nettype wire
